FILE: sv/epcal_pkg.sv
// Shared types, constants and lookup functions of the epoch/calendar converter.
`timescale 1ns / 1ps
package epcal_pkg;

	localparam logic [15:0] YEAR_MIN       = 16'd1970;
	localparam logic [15:0] YEAR_MAX       = 16'd2199;
	localparam logic [15:0] YEAR_NO_LEAP   = 16'd2100;
	localparam logic [16:0] SECS_PER_HOUR  = 17'd3600;
	localparam logic [9:0]  DAY_ODD_FACTOR = 10'd675;
	localparam int unsigned DAY_SHIFT      = 7;

	// One result travelling down the pipe
	typedef struct packed {
		logic        op;
		logic [32:0] epoch;
		logic [15:0] year;
		logic [7:0]  month;
		logic [7:0]  mday;
		logic [7:0]  hour;
		logic [7:0]  minute;
		logic [7:0]  second;
		logic [2:0]  weekday;
		logic        time_valid;
		logic        converted;
	} res_t;

	// Result plus epoch split into whole days and seconds of day
	typedef struct packed {
		res_t        res;
		logic [16:0] days;
		logic [16:0] rem;
	} daysec_t;

	function automatic logic [8:0] days_before_month(input logic [3:0] idx);
		logic [8:0] v;
		unique case (idx)
			4'd0:    v = 9'd0;
			4'd1:    v = 9'd31;
			4'd2:    v = 9'd59;
			4'd3:    v = 9'd90;
			4'd4:    v = 9'd120;
			4'd5:    v = 9'd151;
			4'd6:    v = 9'd181;
			4'd7:    v = 9'd212;
			4'd8:    v = 9'd243;
			4'd9:    v = 9'd273;
			4'd10:   v = 9'd304;
			4'd11:   v = 9'd334;
			default: v = 9'd0;
		endcase
		return v;
	endfunction

	function automatic logic [4:0] days_in_month(input logic [3:0] idx);
		logic [4:0] v;
		unique case (idx)
			4'd1:                         v = 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10:      v = 5'd30;
			default:                      v = 5'd31;
		endcase
		return v;
	endfunction

	// First day of year (March based) of month index mp
	function automatic logic [8:0] mp_day_offset(input logic [3:0] mp);
		logic [8:0] v;
		unique case (mp)
			4'd0:    v = 9'd0;
			4'd1:    v = 9'd31;
			4'd2:    v = 9'd61;
			4'd3:    v = 9'd92;
			4'd4:    v = 9'd122;
			4'd5:    v = 9'd153;
			4'd6:    v = 9'd184;
			4'd7:    v = 9'd214;
			4'd8:    v = 9'd245;
			4'd9:    v = 9'd275;
			4'd10:   v = 9'd306;
			4'd11:   v = 9'd337;
			default: v = 9'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: sv/epcal_c2e.sv
// Calendar to epoch stages: field checks, day count, seconds.
`timescale 1ns / 1ps
module epcal_c2e (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic               op,
	input  logic [32:0]        epoch_in,
	input  logic [15:0]        year_in,
	input  logic [7:0]         month_in,
	input  logic [7:0]         mday_in,
	input  logic [7:0]         hour_in,
	input  logic [7:0]         minute_in,
	input  logic [7:0]         second_in,
	input  logic [7:0]         weekday_in,
	output logic               out_valid,
	output epcal_pkg::res_t    out_res
);
	import epcal_pkg::*;

	logic        mo_ok, yr_ok, conv, leap, day_ok, valid0;
	logic [15:0] yl, ya, yb, ys;
	logic [25:0] pa, dsum;
	logic [23:0] pb;
	logic [3:0]  midx;
	logic [8:0]  dbm;
	logic [4:0]  mlen;
	logic [13:0] lq;
	logic [19:0] hms;
	res_t        base;

	logic        v_s1, v_s2;
	res_t        base_s1, base_s2;
	logic [15:0] ys_s1, ya_s1, yb_s1;
	logic [25:0] dsum_s1, days_s2;
	logic [13:0] lq_s1;
	logic [9:0]  qa_s1;
	logic [7:0]  qb_s1;
	logic [19:0] hms_s1, hms_s2;

	logic [15:0] ra, rb;
	logic [9:0]  qa;
	logic [7:0]  qb;
	logic [25:0] days;
	logic [42:0] prod;
	logic [32:0] ep0, ep;
	res_t        res3;

	// stage 1: checks and reciprocal estimates
	always_comb begin
		mo_ok  = (month_in >= 8'd1) && (month_in <= 8'd12);
		yr_ok  = (year_in >= YEAR_MIN);
		conv   = mo_ok && yr_ok;
		yl     = (month_in < 8'd3) ? year_in - 16'd1 : year_in;
		ya     = yl - 16'd1900;
		yb     = yl - 16'd1600;
		ys     = year_in - YEAR_MIN;
		pa     = 26'(ya) * 26'd655;
		pb     = 24'(yb) * 24'd163;
		midx   = mo_ok ? 4'(month_in[3:0] - 4'd1) : 4'd0;
		dbm    = days_before_month(midx);
		mlen   = days_in_month(midx);
		leap   = (year_in[1:0] == 2'b00) && (year_in != YEAR_NO_LEAP);
		day_ok = (mday_in != 8'd0) && ((mday_in <= {3'b000, mlen}) ||
			((month_in == 8'd2) && (mday_in == 8'd29) && leap));
		valid0 = (weekday_in < 8'd7) && yr_ok && (year_in <= YEAR_MAX) && mo_ok &&
			day_ok && (hour_in < 8'd24) && (minute_in < 8'd60) && (second_in < 8'd60);
		dsum   = 26'(dbm) + 26'(mday_in) - 26'd1;
		lq     = 14'((yl - 16'd1968) >> 2);
		hms    = 20'(hour_in) * 20'd3600 + 20'(minute_in) * 20'd60 + 20'(second_in);
		base            = '0;
		base.op         = op;
		base.epoch      = epoch_in;
		base.year       = year_in;
		base.month      = month_in;
		base.mday       = mday_in;
		base.hour       = hour_in;
		base.minute     = minute_in;
		base.second     = second_in;
		base.time_valid = valid0;
		base.converted  = op | conv;
	end

	// stage 2: correct quotients, sum the day count
	always_comb begin
		ra   = ya_s1 - 16'(qa_s1) * 16'd100;
		qa   = qa_s1 + {9'b0, ra >= 16'd100};
		rb   = yb_s1 - 16'(qb_s1) * 16'd400;
		qb   = qb_s1 + {7'b0, rb >= 16'd400};
		days = 26'(ys_s1) * 26'd365 + dsum_s1 + 26'(lq_s1) - 26'(qa) + 26'(qb);
	end

	// stage 3: seconds, wrapped to 33 bits
	always_comb begin
		prod = 43'(days_s2) * 43'd86400;
		ep0  = prod[32:0] + 33'(hms_s2);
		ep   = base_s2.op ? base_s2.epoch : (base_s2.converted ? ep0 : 33'd0);
		res3       = base_s2;
		res3.epoch = ep;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			base_s1       <= base;
			ys_s1         <= ys;
			ya_s1         <= ya;
			yb_s1         <= yb;
			dsum_s1       <= dsum;
			lq_s1         <= lq;
			qa_s1         <= pa[25:16];
			qb_s1         <= pb[23:16];
			hms_s1        <= hms;
			base_s2       <= base_s1;
			days_s2       <= days;
			hms_s2        <= hms_s1;
			out_res       <= res3;
		end
	end

endmodule

FILE: sv/epcal_div.sv
// Split epoch seconds into whole days and seconds of day.
`timescale 1ns / 1ps
module epcal_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  epcal_pkg::res_t      in_res,
	output logic                 out_valid,
	output epcal_pkg::daysec_t   out_ds
);
	import epcal_pkg::*;

	logic [25:0] hi;
	logic [42:0] pq;
	logic        v_s4;
	res_t        base_s4;
	logic [16:0] qe_s4;
	logic [25:0] r;
	logic        rc;
	logic [16:0] q;
	logic [9:0]  r675;

	// 86400 = 675 << 7: divide the upper bits by 675
	assign hi = in_res.epoch[32:DAY_SHIFT];
	assign pq = 43'(hi) * 43'd99420;

	always_comb begin
		r    = base_s4.epoch[32:DAY_SHIFT] - 26'(qe_s4) * 26'(DAY_ODD_FACTOR);
		rc   = (r >= 26'(DAY_ODD_FACTOR));
		q    = qe_s4 + {16'b0, rc};
		r675 = rc ? 10'(r - 26'(DAY_ODD_FACTOR)) : r[9:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s4      <= in_valid;
			out_valid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			base_s4     <= in_res;
			qe_s4       <= pq[42:26];
			out_ds.res  <= base_s4;
			out_ds.days <= q;
			out_ds.rem  <= {r675, base_s4.epoch[DAY_SHIFT-1:0]};
		end
	end

endmodule

FILE: sv/epcal_e2c.sv
// Days and seconds of day to calendar fields and weekday.
`timescale 1ns / 1ps
module epcal_e2c (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  epcal_pkg::daysec_t   in_ds,
	output logic                 out_valid,
	output epcal_pkg::res_t      out_res
);
	import epcal_pkg::*;

	logic [6:0] v_q;
	res_t       base_s6, base_s7, base_s8, base_s9, base_s10, base_s11, base_s12;
	logic       era_s6, era_s7, era_s8, era_s9, era_s10, era_s11, era_s12;

	// stage 6
	logic [22:0] ph;
	logic [16:0] w_in;
	logic [31:0] pw;
	logic [19:0] z;
	logic        era5;
	logic [17:0] doe;
	logic [16:0] rem_s6, w_in_s6;
	logic [5:0]  he_s6;
	logic [14:0] we_s6;
	logic [17:0] doe_s6;

	always_comb begin
		ph   = 23'(in_ds.rem) * 23'd36;
		w_in = in_ds.days + 17'd3;
		pw   = 32'(w_in) * 32'd18724;
		z    = 20'(in_ds.days) + 20'd719468;
		era5 = (z >= 20'd730485);
		doe  = 18'(z - (era5 ? 20'd730485 : 20'd584388));
	end

	// stage 7
	logic [16:0] rh;
	logic        hc;
	logic [16:0] rw;
	logic [25:0] p1460;
	logic [2:0]  c36;
	logic [4:0]  h_s7;
	logic [11:0] rh_s7;
	logic [2:0]  wd_s7, c36_s7;
	logic [17:0] doe_s7;
	logic [7:0]  q1460e_s7;
	logic        c146_s7;

	always_comb begin
		rh    = rem_s6 - 17'(he_s6) * SECS_PER_HOUR;
		hc    = (rh >= SECS_PER_HOUR);
		rw    = w_in_s6 - 17'(we_s6) * 17'd7;
		p1460 = 26'(doe_s6) * 26'd179;
		c36   = 3'(doe_s6 >= 18'd36524) + 3'(doe_s6 >= 18'd73048) +
			3'(doe_s6 >= 18'd109572) + 3'(doe_s6 >= 18'd146096);
	end

	// stage 8
	logic [17:0] r1460, t;
	logic [7:0]  q1460;
	logic [18:0] pm;
	logic [4:0]  h_s8;
	logic [11:0] rh_s8;
	logic [2:0]  wd_s8;
	logic [17:0] doe_s8, t_s8;
	logic [6:0]  mie_s8;

	always_comb begin
		r1460 = doe_s7 - 18'(q1460e_s7) * 18'd1460;
		q1460 = q1460e_s7 + {7'b0, r1460 >= 18'd1460};
		t     = doe_s7 - 18'(q1460) + 18'(c36_s7) - 18'(c146_s7);
		pm    = 19'(rh_s7) * 19'd68;
	end

	// stage 9
	logic [11:0] rmi;
	logic        mc;
	logic [27:0] py;
	logic [4:0]  h_s9;
	logic [5:0]  mi_s9, sec_s9;
	logic [2:0]  wd_s9;
	logic [17:0] doe_s9, t_s9;
	logic [9:0]  ye_s9;

	always_comb begin
		rmi = rh_s8 - 12'(mie_s8) * 12'd60;
		mc  = (rmi >= 12'd60);
		py  = 28'(t_s8) * 28'd718;
	end

	// stage 10
	logic [17:0] ry;
	logic [4:0]  h_s10;
	logic [5:0]  mi_s10, sec_s10;
	logic [2:0]  wd_s10;
	logic [17:0] doe_s10;
	logic [8:0]  yoe_s10;

	assign ry = t_s9 - 18'(ye_s9) * 18'd365;

	// stage 11
	logic [1:0]  c100;
	logic [17:0] doy_w;
	logic [4:0]  h_s11;
	logic [5:0]  mi_s11, sec_s11;
	logic [2:0]  wd_s11;
	logic [8:0]  yoe_s11, doy_s11;

	always_comb begin
		c100  = 2'(yoe_s10 >= 9'd100) + 2'(yoe_s10 >= 9'd200) + 2'(yoe_s10 >= 9'd300);
		doy_w = doe_s10 - (18'(yoe_s10) * 18'd365 + 18'(yoe_s10 >> 2) - 18'(c100));
	end

	// stage 12
	logic [10:0] x5;
	logic [14:0] pmp;
	logic [4:0]  h_s12;
	logic [5:0]  mi_s12, sec_s12;
	logic [2:0]  wd_s12;
	logic [8:0]  yoe_s12, doy_s12;
	logic [10:0] x5_s12;
	logic [3:0]  mpe_s12;

	always_comb begin
		x5  = 11'(doy_s11) * 11'd5 + 11'd2;
		pmp = 15'(x5) * 15'd13;
	end

	// stage 13: month, day, year, final result
	logic [10:0] rmp;
	logic [3:0]  mp, mo;
	logic [8:0]  dd;
	logic [15:0] yy;
	res_t        res;

	always_comb begin
		rmp = x5_s12 - 11'(mpe_s12) * 11'd153;
		mp  = mpe_s12 + {3'b0, rmp >= 11'd153};
		dd  = doy_s12 - mp_day_offset(mp) + 9'd1;
		mo  = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
		yy  = 16'(yoe_s12) + (era_s12 ? 16'd2000 : 16'd1600) + 16'(mo <= 4'd2);
		res = base_s12;
		res.weekday = base_s12.converted ? wd_s12 : 3'd0;
		if (base_s12.op) begin
			res.year       = yy;
			res.month      = 8'(mo);
			res.mday       = 8'(dd);
			res.hour       = 8'(h_s12);
			res.minute     = 8'(mi_s12);
			res.second     = 8'(sec_s12);
			res.time_valid = (yy <= YEAR_MAX);
		end
	end

	// one valid bit per stage 6..12, oldest at the top; out_valid goes with out_res
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q       <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_q       <= {v_q[5:0], in_valid};
			out_valid <= v_q[6];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			base_s6   <= in_ds.res;
			era_s6    <= era5;
			rem_s6    <= in_ds.rem;
			w_in_s6   <= w_in;
			he_s6     <= ph[22:17];
			we_s6     <= pw[31:17];
			doe_s6    <= doe;

			base_s7   <= base_s6;
			era_s7    <= era_s6;
			h_s7      <= 5'(he_s6 + {5'b0, hc});
			rh_s7     <= hc ? 12'(rh - SECS_PER_HOUR) : rh[11:0];
			wd_s7     <= (rw >= 17'd7) ? 3'(rw - 17'd7) : rw[2:0];
			doe_s7    <= doe_s6;
			q1460e_s7 <= p1460[25:18];
			c36_s7    <= c36;
			c146_s7   <= (doe_s6 == 18'd146096);

			base_s8   <= base_s7;
			era_s8    <= era_s7;
			h_s8      <= h_s7;
			rh_s8     <= rh_s7;
			wd_s8     <= wd_s7;
			doe_s8    <= doe_s7;
			t_s8      <= t;
			mie_s8    <= pm[18:12];

			base_s9   <= base_s8;
			era_s9    <= era_s8;
			h_s9      <= h_s8;
			mi_s9     <= 6'(mie_s8 + {6'b0, mc});
			sec_s9    <= mc ? 6'(rmi - 12'd60) : rmi[5:0];
			wd_s9     <= wd_s8;
			doe_s9    <= doe_s8;
			t_s9      <= t_s8;
			ye_s9     <= py[27:18];

			base_s10  <= base_s9;
			era_s10   <= era_s9;
			h_s10     <= h_s9;
			mi_s10    <= mi_s9;
			sec_s10   <= sec_s9;
			wd_s10    <= wd_s9;
			doe_s10   <= doe_s9;
			yoe_s10   <= 9'(ye_s9 + {9'b0, ry >= 18'd365});

			base_s11  <= base_s10;
			era_s11   <= era_s10;
			h_s11     <= h_s10;
			mi_s11    <= mi_s10;
			sec_s11   <= sec_s10;
			wd_s11    <= wd_s10;
			yoe_s11   <= yoe_s10;
			doy_s11   <= doy_w[8:0];

			base_s12  <= base_s11;
			era_s12   <= era_s11;
			h_s12     <= h_s11;
			mi_s12    <= mi_s11;
			sec_s12   <= sec_s11;
			wd_s12    <= wd_s11;
			yoe_s12   <= yoe_s11;
			doy_s12   <= doy_s11;
			x5_s12    <= x5;
			mpe_s12   <= pmp[14:11];

			out_res   <= res;
		end
	end

endmodule

FILE: sv/epcal_obuf.sv
// Two-entry output buffer between the pipe and the result channel.
`timescale 1ns / 1ps
module epcal_obuf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  epcal_pkg::res_t    in_res,
	output logic               ready,
	output logic               out_valid,
	input  logic               out_stall,
	output epcal_pkg::res_t    out_res
);
	import epcal_pkg::*;

	res_t       mem_q [2];
	logic [1:0] count_q;
	logic       wr_q, rd_q, push, pop;

	assign ready     = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_res   = mem_q[rd_q];
	assign push      = in_valid && ready;
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_res;
	end

endmodule

FILE: sv/epoch_calendar_converter.sv
// Top level of the epoch / Gregorian calendar converter.
// Throughput: one request per cycle while in_stall is low; thirteen pipe stages
// move together and the two-entry output buffer decouples them from the result
// channel's stall.
// in_stall comes straight from the buffer's full flag (a register).
// Reset clears every stage valid bit and the buffer count; no clearing pass.
`timescale 1ns / 1ps
module epoch_calendar_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [32:0] epoch_in,
	input  logic [15:0] year_in,
	input  logic [7:0]  month_in,
	input  logic [7:0]  mday_in,
	input  logic [7:0]  hour_in,
	input  logic [7:0]  minute_in,
	input  logic [7:0]  second_in,
	input  logic [7:0]  weekday_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [32:0] epoch_out,
	output logic [15:0] year_out,
	output logic [7:0]  month_out,
	output logic [7:0]  mday_out,
	output logic [7:0]  hour_out,
	output logic [7:0]  minute_out,
	output logic [7:0]  second_out,
	output logic [2:0]  weekday_out,
	output logic        time_valid,
	output logic        converted
);
	import epcal_pkg::*;

	// Pipe enable: advance every stage while the buffer has room for one more
	// request; hold everything otherwise.
	logic    en;
	logic    c2e_valid, div_valid, e2c_valid;
	res_t    c2e_res, e2c_res, buf_res;
	daysec_t div_ds;

	assign in_stall = !en;

	// Stages 1-3: validate calendar fields and build epoch seconds for op 0;
	// op 1 passes its epoch straight through.
	epcal_c2e u_c2e (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (in_valid),
		.op         (op),
		.epoch_in   (epoch_in),
		.year_in    (year_in),
		.month_in   (month_in),
		.mday_in    (mday_in),
		.hour_in    (hour_in),
		.minute_in  (minute_in),
		.second_in  (second_in),
		.weekday_in (weekday_in),
		.out_valid  (c2e_valid),
		.out_res    (c2e_res)
	);

	// Stages 4-5: epoch divided by 86400 through a reciprocal estimate
	// and one correction step.
	epcal_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (c2e_valid),
		.in_res    (c2e_res),
		.out_valid (div_valid),
		.out_ds    (div_ds)
	);

	// Stages 6-13: time of day, weekday, and the era/year/month decomposition
	// of the day count; op 0 keeps its echoed fields and only takes the weekday.
	epcal_e2c u_e2c (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (div_valid),
		.in_ds     (div_ds),
		.out_valid (e2c_valid),
		.out_res   (e2c_res)
	);

	// Output buffer absorbs the result in flight when the channel stalls.
	epcal_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (e2c_valid),
		.in_res    (e2c_res),
		.ready     (en),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (buf_res)
	);

	assign epoch_out   = buf_res.epoch;
	assign year_out    = buf_res.year;
	assign month_out   = buf_res.month;
	assign mday_out    = buf_res.mday;
	assign hour_out    = buf_res.hour;
	assign minute_out  = buf_res.minute;
	assign second_out  = buf_res.second;
	assign weekday_out = buf_res.weekday;
	assign time_valid  = buf_res.time_valid;
	assign converted   = buf_res.converted;

	// A refused conversion carries zero epoch and weekday.
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !converted |-> (epoch_out == 33'd0) && (weekday_out == 3'd0))
		else $error("refused request with nonzero epoch or weekday");

	// Legal fields imply the conversion took place.
	a_valid_conv: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && time_valid |-> converted)
		else $error("time_valid without converted");

	// Weekday stays in Monday..Sunday.
	a_weekday: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (weekday_out <= 3'd6))
		else $error("weekday out of range");

	// Legal result carries a legal month and hour.
	a_legal_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && time_valid |->
		(month_out >= 8'd1) && (month_out <= 8'd12) && (hour_out < 8'd24))
		else $error("time_valid with illegal month or hour");

endmodule
